[design/ssor_preconditioner_apply_macros.svh]
// Assertion macros used by the checker file of the SSOR block.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef SSOR_PRECONDITIONER_APPLY_MACROS_SVH
`define SSOR_PRECONDITIONER_APPLY_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SSOR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssor assertion failed");

// Next-cycle implication, disabled during reset.
`define SSOR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssor assertion failed");

`endif

[design/ssor_pkg.sv]
// Package of the SSOR preconditioner block: widths, codes and state types.
// Used by the top level and by its checker; depends on nothing.
package ssor_pkg;

  localparam int MAX_DIM_DEF     = 64;
  localparam int MAX_ENTRIES_DEF = 512;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int VAL_W      = 32;
  localparam int CMD_W      = 3;
  localparam int IDX_W      = 6;
  localparam int RELAX_W    = 17;
  localparam int SIZE_W     = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;
  localparam int STATUS_W   = 2;
  localparam int DIV_STEPS  = 64;
  localparam int DIV_CNT_W  = 6;

  localparam logic [SIZE_W-1:0]    SIZE_RESET = SIZE_W'(64);
  localparam logic [CFG_IDX_W-1:0] CFG_RELAX  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE   = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 3'd0,
    CMD_ADD   = 3'd1,
    CMD_DIAG  = 3'd2,
    CMD_VEC   = 3'd3,
    CMD_RUN   = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_ZERO_DIAG = 2'd1,
    STAT_SAT       = 2'd2,
    STAT_DROPPED   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_FWD   = 2'd0,
    PH_SCALE = 2'd1,
    PH_BWD   = 2'd2,
    PH_FINAL = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_INIT,
    ST_SCAN,
    ST_NARROW,
    ST_MUL,
    ST_DIV_SET,
    ST_DIV,
    ST_DIV_END,
    ST_WB,
    ST_FIN,
    ST_EMIT_RD,
    ST_EMIT_WR
  } state_t;

endpackage

[design/ssor_preconditioner_apply.sv]
// SSOR preconditioner apply, signed fixed point, single-module datapath.
// Depends on ssor_pkg for widths, command and status codes and state types.
//
// Usage: an input word carries a command. Clear, add entry, set diagonal and
// set vector element give no result. A run computes the forward solve, the
// diagonal scaling, the backward solve and the final (2 - omega) scaling,
// then emits one output word per element in index order, with out_last on
// the final one and the same status on all of them.
// Configuration words (omega, size) are taken at any time on the cfg channel.
// Flow: in_ready is high only while the block is idle. In a run each solved
// row walks all stored entries once through a read/multiply/accumulate
// pipeline, and each element of the solves and the scaling goes through the
// shared radix-2 divider (64 steps) unless its divisor is zero. Each output
// word passes through the ST_EMIT_RD and ST_EMIT_WR states.
// Reset: omega is 1.0, size is 64, the entry store is empty and all
// diagonals and vector elements read as zero. No clearing pass is needed.
// Stall: a stalled receiver holds the output register; emission waits and
// resumes when the word is taken.
module ssor_preconditioner_apply
  import ssor_pkg::*;
#(
  parameter int MAX_DIM     = MAX_DIM_DEF,
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [CMD_W-1:0]        in_command,
  input  logic [IDX_W-1:0]        in_row_index,
  input  logic [IDX_W-1:0]        in_col_index,
  input  logic signed [VAL_W-1:0] in_operand,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [IDX_W-1:0]        out_index,
  output logic signed [VAL_W-1:0] out_value,
  output logic                    out_last,
  output logic [STATUS_W-1:0]     out_status,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int EA_W   = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int PROD_W = 2 * VAL_W + 1;
  localparam int ACC_W  = PROD_W + CNT_W;
  localparam int MB_W   = VAL_W + 1;
  localparam int ENT_W  = 2 * DIM_W + VAL_W;
  localparam int QW     = 2 * VAL_W;

  localparam logic [IDX_W:0]      DIM_LIM     = (IDX_W + 1)'(MAX_DIM);
  localparam logic [SIZE_W-1:0]   SIZE_LIM    = SIZE_W'(MAX_DIM);
  localparam logic [CNT_W-1:0]    ENT_LIM     = CNT_W'(MAX_ENTRIES);
  localparam logic [RELAX_W-1:0]  RELAX_RESET = RELAX_W'(64'd1 << FRAC_BITS);
  localparam logic signed [MB_W-1:0] TWO_Q    = MB_W'(64'd2 << FRAC_BITS);
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [ACC_W-1:0] LIM_POS = ACC_W'({1'b0, {(VAL_W-1){1'b1}}});
  localparam logic [ACC_W-1:0] LIM_NEG = ACC_W'({1'b1, {(VAL_W-1){1'b0}}});
  localparam logic [QW-1:0]    QLIM_POS = QW'({1'b0, {(VAL_W-1){1'b1}}});
  localparam logic [QW-1:0]    QLIM_NEG = QW'({1'b1, {(VAL_W-1){1'b0}}});

  state_t state_r, state_nxt;
  phase_t phase_r;

  logic [RELAX_W-1:0] relax_r;
  logic [SIZE_W-1:0]  size_r;
  logic [CNT_W-1:0]   count_r;
  logic               dropped_r;
  logic [MAX_DIM-1:0] dvalid_r;
  logic [MAX_DIM-1:0] vvalid_r;
  logic [DIM_W-1:0]   i_r;
  logic [DIM_W-1:0]   nm1_r;
  logic [CNT_W-1:0]   k_r;
  logic               p1_v_r, p2_v_r, p3_v_r;
  logic signed [VAL_W-1:0]  p2val_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [VAL_W-1:0]  d_r;
  logic signed [VAL_W-1:0]  r_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [QW-1:0]            nq_r;
  logic [VAL_W-1:0]         dmag_r;
  logic [VAL_W:0]           rem_r;
  logic                     neg_r;
  logic [DIV_CNT_W-1:0]     cnt_r;
  logic signed [VAL_W-1:0]  res_r;
  logic                     zd_r, sat_r;
  logic                     out_valid_r;
  logic [IDX_W-1:0]         out_index_r;
  logic signed [VAL_W-1:0]  out_value_r;
  logic                     out_last_r;
  logic [STATUS_W-1:0]      out_status_r;

  logic [ENT_W-1:0]        ent_mem [MAX_ENTRIES];
  logic signed [VAL_W-1:0] diag_mem [MAX_DIM];
  logic signed [VAL_W-1:0] vec_mem [MAX_DIM];
  logic signed [VAL_W-1:0] work_mem [MAX_DIM];

  logic [ENT_W-1:0]        ent_rd_r;
  logic signed [VAL_W-1:0] diag_rd_r, vec_rd_r, work_rd_r;
  logic                    dvld_rd_r, vvld_rd_r;

  logic                    in_acc;
  logic                    row_ok, ent_ok;
  logic [DIM_W-1:0]        row_a, col_a;
  logic [DIM_W-1:0]        e_row, e_col;
  logic signed [VAL_W-1:0] e_val;
  logic                    match;
  logic                    issue;
  logic                    scan_done;
  logic signed [VAL_W-1:0] diag_val, vec_val;
  logic signed [MB_W-1:0]  factor;
  logic signed [VAL_W-1:0] mult_a;
  logic signed [MB_W-1:0]  mult_b;
  logic [DIM_W-1:0]        work_rd_addr;
  logic                    work_we;
  logic signed [VAL_W-1:0] work_wdata;
  logic [ACC_W-1:0]        nar_src, nar_mag, nar_q;
  logic                    nar_neg, nar_sat;
  logic signed [VAL_W-1:0] nar_val;
  logic                    den_zero;
  logic                    num_neg;
  logic [PROD_W-1:0]       num_mag;
  logic [VAL_W:0]          rem_sh;
  logic                    q_bit;
  logic [DIM_W-1:0]        nm1_run;
  status_t                 status_now;

  assign in_ready   = (state_r == ST_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign cfg_ready  = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_index  = out_index_r;
  assign out_value  = out_value_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

  assign row_ok = {1'b0, in_row_index} < DIM_LIM;
  assign row_a  = in_row_index[DIM_W-1:0];
  assign col_a  = in_col_index[DIM_W-1:0];
  assign ent_ok = (in_col_index < in_row_index) && row_ok && (count_r < ENT_LIM);

  assign e_row = ent_rd_r[ENT_W-1 -: DIM_W];
  assign e_col = ent_rd_r[VAL_W +: DIM_W];
  assign e_val = ent_rd_r[VAL_W-1:0];
  assign match = (phase_r == PH_FWD) ? (e_row == i_r)
               : ((e_col == i_r) && (e_row > i_r) && (e_row <= nm1_r));
  assign issue     = (k_r < count_r);
  assign scan_done = !issue && !p1_v_r && !p2_v_r && !p3_v_r;

  assign diag_val = dvld_rd_r ? diag_rd_r : '0;
  assign vec_val  = vvld_rd_r ? vec_rd_r : '0;
  assign factor   = TWO_Q - $signed(MB_W'(relax_r));

  always_comb begin
    if (size_r == '0) begin
      nm1_run = '0;
    end else if (size_r > SIZE_LIM) begin
      nm1_run = DIM_W'(MAX_DIM - 1);
    end else begin
      nm1_run = DIM_W'(size_r - 1'b1);
    end
  end

  // Truncating, saturating narrow by 2^FRAC_BITS, shared by solve and final steps.
  always_comb begin
    nar_src = (state_r == ST_FIN) ? ACC_W'(prod_r) : acc_r;
    nar_neg = nar_src[ACC_W-1];
    nar_mag = nar_neg ? (~nar_src + 1'b1) : nar_src;
    nar_q   = nar_mag >> FRAC_BITS;
    nar_sat = nar_neg ? (nar_q > LIM_NEG) : (nar_q > LIM_POS);
    if (nar_sat) begin
      nar_val = nar_neg ? VAL_MIN : VAL_MAX;
    end else begin
      nar_val = nar_neg ? -$signed(nar_q[VAL_W-1:0]) : $signed(nar_q[VAL_W-1:0]);
    end
  end

  always_comb begin
    den_zero = (phase_r == PH_SCALE) ? (relax_r == '0) : (d_r == '0);
    num_neg  = prod_r[PROD_W-1];
    num_mag  = num_neg ? (~prod_r + 1'b1) : prod_r;
    rem_sh   = {rem_r[VAL_W-1:0], nq_r[QW-1]};
    q_bit    = (rem_sh >= {1'b0, dmag_r});
  end

  always_comb begin
    if (zd_r) begin
      status_now = STAT_ZERO_DIAG;
    end else if (sat_r) begin
      status_now = STAT_SAT;
    end else if (dropped_r) begin
      status_now = STAT_DROPPED;
    end else begin
      status_now = STAT_OK;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_acc && (in_command == CMD_RUN)) state_nxt = ST_RD;
      ST_RD:      state_nxt = ST_INIT;
      ST_INIT: begin
        unique case (phase_r)
          PH_FWD, PH_BWD: state_nxt = ST_SCAN;
          PH_SCALE:       state_nxt = ST_DIV_SET;
          PH_FINAL:       state_nxt = ST_FIN;
          default:        state_nxt = ST_IDLE;
        endcase
      end
      ST_SCAN:    if (scan_done) state_nxt = ST_NARROW;
      ST_NARROW:  state_nxt = ST_MUL;
      ST_MUL:     state_nxt = ST_DIV_SET;
      ST_DIV_SET: state_nxt = den_zero ? ST_WB : ST_DIV;
      ST_DIV:     if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) state_nxt = ST_DIV_END;
      ST_DIV_END: state_nxt = ST_WB;
      ST_WB:      state_nxt = ST_RD;
      ST_FIN:     state_nxt = (i_r == nm1_r) ? ST_EMIT_RD : ST_RD;
      ST_EMIT_RD: if (!out_valid_r || out_ready) state_nxt = ST_EMIT_WR;
      ST_EMIT_WR: state_nxt = (i_r == nm1_r) ? ST_IDLE : ST_EMIT_RD;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mult_a       = '0;
    mult_b       = '0;
    work_we      = 1'b0;
    work_wdata   = res_r;
    work_rd_addr = i_r;
    unique case (state_r)
      ST_SCAN: begin
        mult_a       = p2val_r;
        mult_b       = MB_W'(work_rd_r);
        work_rd_addr = (phase_r == PH_FWD) ? e_col : e_row;
      end
      ST_INIT: begin
        mult_a = work_rd_r;
        mult_b = (phase_r == PH_SCALE) ? MB_W'(diag_val) : factor;
      end
      ST_MUL: begin
        mult_a = r_r;
        mult_b = $signed(MB_W'(relax_r));
      end
      ST_WB: begin
        work_we = 1'b1;
      end
      ST_FIN: begin
        work_we    = 1'b1;
        work_wdata = nar_val;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_command == CMD_ADD) && ent_ok) begin
      ent_mem[count_r[EA_W-1:0]] <= {row_a, col_a, in_operand};
    end
    ent_rd_r <= ent_mem[k_r[EA_W-1:0]];
    if (in_acc && (in_command == CMD_DIAG) && row_ok) begin
      diag_mem[row_a] <= in_operand;
    end
    diag_rd_r <= diag_mem[i_r];
    if (in_acc && (in_command == CMD_VEC) && row_ok) begin
      vec_mem[row_a] <= in_operand;
    end
    vec_rd_r <= vec_mem[i_r];
    if (work_we) begin
      work_mem[i_r] <= work_wdata;
    end
    work_rd_r <= work_mem[work_rd_addr];
  end

  always_ff @(posedge clk) begin
    prod_r <= mult_a * mult_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      phase_r      <= PH_FWD;
      relax_r      <= RELAX_RESET;
      size_r       <= SIZE_RESET;
      count_r      <= '0;
      dropped_r    <= 1'b0;
      dvalid_r     <= '0;
      vvalid_r     <= '0;
      dvld_rd_r    <= 1'b0;
      vvld_rd_r    <= 1'b0;
      i_r          <= '0;
      nm1_r        <= '0;
      k_r          <= '0;
      p1_v_r       <= 1'b0;
      p2_v_r       <= 1'b0;
      p3_v_r       <= 1'b0;
      cnt_r        <= '0;
      zd_r         <= 1'b0;
      sat_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      dvld_rd_r <= dvalid_r[i_r];
      vvld_rd_r <= vvalid_r[i_r];

      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_RELAX) begin
          relax_r <= cfg_data[RELAX_W-1:0];
        end else if (cfg_index == CFG_SIZE) begin
          size_r <= cfg_data[SIZE_W-1:0];
        end
      end

      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (in_command)
              CMD_CLEAR: begin
                count_r   <= '0;
                dropped_r <= 1'b0;
                dvalid_r  <= '0;
              end
              CMD_ADD: begin
                if (ent_ok) begin
                  count_r <= count_r + 1'b1;
                end else begin
                  dropped_r <= 1'b1;
                end
              end
              CMD_DIAG: if (row_ok) dvalid_r[row_a] <= 1'b1;
              CMD_VEC:  if (row_ok) vvalid_r[row_a] <= 1'b1;
              CMD_RUN: begin
                phase_r <= PH_FWD;
                i_r     <= '0;
                nm1_r   <= nm1_run;
                zd_r    <= 1'b0;
                sat_r   <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_INIT: begin
          acc_r  <= (phase_r == PH_FWD) ? (ACC_W'(vec_val) <<< FRAC_BITS)
                                        : (ACC_W'(work_rd_r) <<< FRAC_BITS);
          d_r    <= diag_val;
          k_r    <= '0;
          p1_v_r <= 1'b0;
          p2_v_r <= 1'b0;
          p3_v_r <= 1'b0;
        end
        ST_SCAN: begin
          if (issue) begin
            k_r <= k_r + 1'b1;
          end
          p1_v_r  <= issue;
          p2_v_r  <= p1_v_r && match;
          p2val_r <= e_val;
          p3_v_r  <= p2_v_r;
          if (p3_v_r) begin
            acc_r <= acc_r - ACC_W'(prod_r);
          end
        end
        ST_NARROW: begin
          r_r <= nar_val;
          if (nar_sat) sat_r <= 1'b1;
        end
        ST_DIV_SET: begin
          if (den_zero) begin
            if (phase_r == PH_SCALE) begin
              sat_r <= 1'b1;
            end else begin
              zd_r <= 1'b1;
            end
            if (prod_r == '0) begin
              res_r <= '0;
            end else begin
              res_r <= num_neg ? VAL_MIN : VAL_MAX;
            end
          end else begin
            nq_r  <= num_mag[QW-1:0];
            rem_r <= '0;
            cnt_r <= '0;
            if (phase_r == PH_SCALE) begin
              dmag_r <= VAL_W'(relax_r);
              neg_r  <= num_neg;
            end else begin
              dmag_r <= d_r[VAL_W-1] ? (~d_r + 1'b1) : d_r;
              neg_r  <= num_neg ^ d_r[VAL_W-1];
            end
          end
        end
        ST_DIV: begin
          rem_r <= q_bit ? (rem_sh - {1'b0, dmag_r}) : rem_sh;
          nq_r  <= {nq_r[QW-2:0], q_bit};
          cnt_r <= cnt_r + 1'b1;
        end
        ST_DIV_END: begin
          if (neg_r) begin
            if (nq_r > QLIM_NEG) begin
              res_r <= VAL_MIN;
              sat_r <= 1'b1;
            end else begin
              res_r <= -$signed(nq_r[VAL_W-1:0]);
            end
          end else begin
            if (nq_r > QLIM_POS) begin
              res_r <= VAL_MAX;
              sat_r <= 1'b1;
            end else begin
              res_r <= $signed(nq_r[VAL_W-1:0]);
            end
          end
        end
        ST_WB: begin
          unique case (phase_r)
            PH_FWD: begin
              if (i_r == nm1_r) begin
                phase_r <= PH_SCALE;
                i_r     <= '0;
              end else begin
                i_r <= i_r + 1'b1;
              end
            end
            PH_SCALE: begin
              if (i_r == nm1_r) begin
                phase_r <= PH_BWD;
              end else begin
                i_r <= i_r + 1'b1;
              end
            end
            PH_BWD: begin
              if (i_r == '0) begin
                phase_r <= PH_FINAL;
              end else begin
                i_r <= i_r - 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        ST_FIN: begin
          if (nar_sat) sat_r <= 1'b1;
          i_r <= (i_r == nm1_r) ? '0 : i_r + 1'b1;
        end
        ST_EMIT_WR: begin
          out_valid_r  <= 1'b1;
          out_index_r  <= IDX_W'(i_r);
          out_value_r  <= work_rd_r;
          out_last_r   <= (i_r == nm1_r);
          out_status_r <= status_now;
          i_r          <= i_r + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[design/ssor_chk.sv]
// Port-level checker for the SSOR block, bound to the top level below.
// Depends on ssor_pkg and on ssor_preconditioner_apply_macros.svh.
`include "ssor_preconditioner_apply_macros.svh"

module ssor_chk
  import ssor_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic [CMD_W-1:0]        in_command,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [IDX_W-1:0]        out_index,
  input logic signed [VAL_W-1:0] out_value,
  input logic                    out_last
);

  `SSOR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_index))
  `SSOR_ASSERT_NEXT(a_out_gap, out_valid && out_ready, !out_valid)
  `SSOR_ASSERT_NEXT(a_run_busy, in_valid && in_ready && (in_command == CMD_RUN), !in_ready)
  `SSOR_ASSERT_NEXT(a_emit_busy, out_valid && out_ready && !out_last, !in_ready)

endmodule

bind ssor_preconditioner_apply ssor_chk u_ssor_chk (.*);

[dv/ssor_preconditioner_apply_tb.sv]
// Self-checking testbench for the SSOR preconditioner apply block.
// Depends on ssor_pkg and ssor_preconditioner_apply; holds its own predictor.
`timescale 1ns / 100ps

module ssor_preconditioner_apply_tb;
  import ssor_pkg::*;

  localparam int WATCHDOG_LIMIT = 100000;
  localparam int LONG_HOLD      = 400;

  typedef struct {
    logic [CMD_W-1:0]        cmd;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] operand;
  } load_word_t;

  typedef struct {
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
    logic                    last;
    logic [STATUS_W-1:0]     status;
  } elem_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_W-1:0] in_command = '0;
  logic [IDX_W-1:0] in_row_index = '0;
  logic [IDX_W-1:0] in_col_index = '0;
  logic signed [VAL_W-1:0] in_operand = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [IDX_W-1:0] out_index;
  logic signed [VAL_W-1:0] out_value;
  logic out_last;
  logic [STATUS_W-1:0] out_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ssor_preconditioner_apply u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_row_index(in_row_index), .in_col_index(in_col_index), .in_operand(in_operand),
    .out_valid(out_valid), .out_ready(out_ready), .out_index(out_index),
    .out_value(out_value), .out_last(out_last), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  load_word_t pending_loads[$];
  elem_t      expected_elems[$];

  logic [IDX_W-1:0]        mat_row[MAX_ENTRIES_DEF];
  logic [IDX_W-1:0]        mat_col[MAX_ENTRIES_DEF];
  logic signed [VAL_W-1:0] mat_val[MAX_ENTRIES_DEF];
  int                      mat_count = 0;
  logic signed [VAL_W-1:0] diag_vals[MAX_DIM_DEF];
  logic signed [VAL_W-1:0] vec_vals[MAX_DIM_DEF];
  logic signed [VAL_W-1:0] work_vals[MAX_DIM_DEF];
  bit                      any_dropped = 0;
  logic [RELAX_W-1:0]      omega = 17'd65536;
  logic [SIZE_W-1:0]       dim_reg = SIZE_RESET;

  int mismatches = 0;
  int runs_taken = 0;
  int elems_checked = 0;
  int loads_queued = 0;
  int settings_used = 0;

  initial begin
    for (int i = 0; i < MAX_DIM_DEF; i++) begin
      diag_vals[i] = '0;
      vec_vals[i] = '0;
    end
  end

  function automatic logic signed [127:0] wide(input logic signed [VAL_W-1:0] v);
    logic signed [127:0] r;
    r = v;
    return r;
  endfunction

  function automatic logic signed [VAL_W-1:0] clamp32(input logic signed [127:0] v,
                                                      inout bit sat);
    if (v > 128'sd2147483647) begin
      sat = 1;
      return 32'sh7fffffff;
    end
    if (v < -128'sd2147483648) begin
      sat = 1;
      return 32'sh80000000;
    end
    return v[VAL_W-1:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] guarded_div(input logic signed [127:0] num,
                                                          input logic signed [127:0] den,
                                                          inout bit by_zero, inout bit sat);
    if (den == 0) begin
      by_zero = 1;
      if (num > 0) return 32'sh7fffffff;
      if (num < 0) return 32'sh80000000;
      return '0;
    end
    return clamp32(num / den, sat);
  endfunction

  function automatic logic signed [VAL_W-1:0] relax_row(input logic signed [127:0] acc,
                                                        input logic signed [VAL_W-1:0] d,
                                                        inout bit zd, inout bit sat);
    logic signed [127:0] r;
    logic signed [127:0] om;
    r = wide(clamp32(acc / 128'sd65536, sat));
    om = {111'b0, omega};
    return guarded_div(r * om, wide(d), zd, sat);
  endfunction

  function automatic int eff_dim();
    if (dim_reg < 1) return 1;
    if (dim_reg > MAX_DIM_DEF) return MAX_DIM_DEF;
    return int'(dim_reg);
  endfunction

  task automatic apply_preconditioner();
    int n;
    bit zd;
    bit sat;
    bit om_zero;
    logic signed [127:0] acc;
    logic signed [127:0] om;
    logic signed [127:0] factor;
    logic [STATUS_W-1:0] st;
    elem_t e;
    n = eff_dim();
    zd = 0;
    sat = 0;
    om = {111'b0, omega};
    for (int i = 0; i < n; i++) begin
      acc = wide(vec_vals[i]) * 128'sd65536;
      for (int k = 0; k < mat_count; k++)
        if (mat_row[k] == i && mat_col[k] < i)
          acc = acc - wide(mat_val[k]) * wide(work_vals[mat_col[k]]);
      work_vals[i] = relax_row(acc, diag_vals[i], zd, sat);
    end
    for (int i = 0; i < n; i++) begin
      om_zero = 0;
      work_vals[i] = guarded_div(wide(work_vals[i]) * wide(diag_vals[i]), om, om_zero, sat);
      if (om_zero) sat = 1;
    end
    for (int i = n - 1; i >= 0; i--) begin
      acc = wide(work_vals[i]) * 128'sd65536;
      for (int k = 0; k < mat_count; k++)
        if (mat_col[k] == i && mat_row[k] > i && mat_row[k] < n)
          acc = acc - wide(mat_val[k]) * wide(work_vals[mat_row[k]]);
      work_vals[i] = relax_row(acc, diag_vals[i], zd, sat);
    end
    factor = 128'sd131072 - om;
    for (int i = 0; i < n; i++)
      work_vals[i] = clamp32((wide(work_vals[i]) * factor) / 128'sd65536, sat);
    if (zd) st = STAT_ZERO_DIAG;
    else if (sat) st = STAT_SAT;
    else if (any_dropped) st = STAT_DROPPED;
    else st = STAT_OK;
    for (int i = 0; i < n; i++) begin
      e.index = i[IDX_W-1:0];
      e.value = work_vals[i];
      e.last = (i == n - 1);
      e.status = st;
      expected_elems.push_back(e);
    end
  endtask

  task automatic absorb_load(input load_word_t w);
    case (w.cmd)
      CMD_CLEAR: begin
        mat_count = 0;
        any_dropped = 0;
        for (int i = 0; i < MAX_DIM_DEF; i++) diag_vals[i] = '0;
      end
      CMD_ADD: begin
        if (w.col < w.row && mat_count < MAX_ENTRIES_DEF) begin
          mat_row[mat_count] = w.row;
          mat_col[mat_count] = w.col;
          mat_val[mat_count] = w.operand;
          mat_count++;
        end else begin
          any_dropped = 1;
        end
      end
      CMD_DIAG: diag_vals[w.row] = w.operand;
      CMD_VEC: vec_vals[w.row] = w.operand;
      CMD_RUN: begin
        runs_taken++;
        apply_preconditioner();
      end
      default: ;
    endcase
  endtask

  int burst_left = 0;
  int gap_left = 0;
  bit sender_hold = 0;
  load_word_t cur_word;
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) absorb_load(cur_word);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_loads.size() > 0 && !sender_hold) begin
          cur_word = pending_loads.pop_front();
          in_command <= cur_word.cmd;
          in_row_index <= cur_word.row;
          in_col_index <= cur_word.col;
          in_operand <= cur_word.operand;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  int stall_mode = 0;
  int stall_count = 0;
  int hold_left = 0;
  bit hold_done = 0;
  elem_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        elems_checked++;
        if (expected_elems.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: index %0d value %0d last %0d status %0d",
                     out_index, out_value, out_last, out_status);
        end else begin
          want = expected_elems.pop_front();
          if (want.index !== out_index || want.value !== out_value ||
              want.last !== out_last || want.status !== out_status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result word differs: exp idx %0d val %0d last %0d st %0d,",
                       want.index, want.value, want.last, want.status,
                       " got idx %0d val %0d last %0d st %0d",
                       out_index, out_value, out_last, out_status);
          end
        end
      end
      if (!hold_done && out_valid && in_valid && !in_ready) begin
        hold_done = 1;
        hold_left = LONG_HOLD;
      end
      if (stall_count == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_count = $urandom_range(20, 80);
      end else begin
        stall_count--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_mode == 0) begin
        out_ready <= 1'b1;
      end else if (stall_mode == 1) begin
        out_ready <= $urandom_range(0, 1);
      end else begin
        out_ready <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("ssor_preconditioner_apply: mismatch");
      $finish;
    end
  end

  task automatic queue_load(input logic [CMD_W-1:0] cmd, input int row, input int col,
                            input logic signed [VAL_W-1:0] operand);
    load_word_t w;
    w.cmd = cmd;
    w.row = row[IDX_W-1:0];
    w.col = col[IDX_W-1:0];
    w.operand = operand;
    pending_loads.push_back(w);
    loads_queued++;
  endtask

  task automatic drain();
    while (pending_loads.size() > 0 || in_valid || expected_elems.size() > 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_index <= idx;
    cfg_data <= data[CFG_DATA_W-1:0];
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_RELAX) omega = data[RELAX_W-1:0];
    else dim_reg = data[SIZE_W-1:0];
    settings_used++;
    @(posedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  function automatic logic signed [VAL_W-1:0] rand_diag();
    logic signed [VAL_W-1:0] d;
    d = $urandom_range(32'h0000_8000, 32'h0004_0000);
    if ($urandom_range(0, 9) == 0) return '0;
    return $urandom_range(0, 1) ? -d : d;
  endfunction

  task automatic queue_system();
    int n;
    int ne;
    int r;
    n = eff_dim();
    if ($urandom_range(0, 2) != 0) queue_load(CMD_CLEAR, $urandom_range(0, 63),
                                              $urandom_range(0, 63), $urandom());
    for (int i = 0; i < n; i++) begin
      queue_load(CMD_DIAG, i, $urandom_range(0, 63), rand_diag());
      queue_load(CMD_VEC, i, $urandom_range(0, 63), rand_operand());
    end
    ne = $urandom_range(0, 10);
    for (int k = 0; k < ne; k++) begin
      if ($urandom_range(0, 7) == 0 || n < 2) begin
        queue_load(CMD_ADD, $urandom_range(0, 63), $urandom_range(0, 63), $urandom());
      end else begin
        r = $urandom_range(1, n - 1);
        queue_load(CMD_ADD, r, $urandom_range(0, r - 1),
                   $signed($urandom_range(0, 32'h0001_0000)) - 32'sh0000_8000);
      end
    end
    if ($urandom_range(0, 3) == 0)
      queue_load(CMD_W'($urandom_range(5, 7)), $urandom_range(0, 63),
                 $urandom_range(0, 63), $urandom());
    queue_load(CMD_RUN, $urandom_range(0, 63), $urandom_range(0, 63), $urandom());
  endtask

  initial begin
    int rv;
    int sz;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    queue_load(CMD_CLEAR, 0, 0, 0);
    queue_load(CMD_ADD, 1, 0, 32'sh0000_4000);
    queue_load(CMD_ADD, 1, 0, 32'sh0000_2000);
    queue_load(CMD_ADD, 63, 62, 32'sh7fffffff);
    queue_load(CMD_ADD, 5, 3, 32'sh80000000);
    queue_load(CMD_ADD, 2, 5, 32'sh0001_0000);
    queue_load(CMD_ADD, 4, 4, 32'sh0001_0000);
    queue_load(CMD_DIAG, 0, 63, 32'sh0002_0000);
    queue_load(CMD_DIAG, 1, 0, 32'shffff_0000);
    queue_load(CMD_DIAG, 63, 0, 32'sh7fffffff);
    queue_load(CMD_VEC, 0, 0, 32'sh7fffffff);
    queue_load(CMD_VEC, 63, 63, 32'sh80000000);
    queue_load(CMD_VEC, 1, 0, 32'sh0001_8000);
    queue_load(3'd5, 63, 63, 32'shffffffff);
    queue_load(3'd7, 0, 0, 0);
    queue_load(CMD_RUN, 0, 0, 0);
    drain();
    write_reg(CFG_SIZE, 4);
    write_reg(CFG_RELAX, 0);
    queue_load(CMD_CLEAR, 0, 0, 0);
    for (int i = 0; i < 4; i++) queue_load(CMD_DIAG, i, 0, 32'sh0001_0000);
    queue_load(CMD_ADD, 3, 1, 32'sh0000_8000);
    queue_load(CMD_RUN, 0, 0, 0);
    drain();
    write_reg(CFG_RELAX, 131071);
    write_reg(CFG_SIZE, 0);
    queue_load(CMD_RUN, 0, 0, 0);
    drain();
    write_reg(CFG_RELAX, 1);
    write_reg(CFG_SIZE, 127);
    queue_load(CMD_RUN, 0, 0, 0);
    drain();

    while (loads_queued < 115) begin
      case ($urandom_range(0, 5))
        0: rv = 131071;
        1: rv = 1;
        2: rv = 65536;
        default: rv = $urandom_range(32'h8000, 32'h18000);
      endcase
      sz = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
      write_reg(CFG_RELAX, rv);
      write_reg(CFG_SIZE, sz);
      sender_hold = ($urandom_range(0, 1) == 0);
      queue_system();
      queue_system();
      repeat (3) @(posedge clk);
      sender_hold = 0;
      drain();
    end

    write_reg(CFG_SIZE, 2);
    write_reg(CFG_RELAX, 65536);
    queue_load(CMD_CLEAR, 0, 0, 0);
    for (int k = 0; k < 3; k++)
      queue_load(CMD_ADD, 1, 0, $signed($urandom_range(0, 32'h200)) - 32'sh100);
    queue_load(CMD_DIAG, 0, 0, 32'sh0001_0000);
    queue_load(CMD_DIAG, 1, 0, 32'sh0001_0000);
    queue_load(CMD_VEC, 0, 0, 32'sh0001_0000);
    queue_load(CMD_RUN, 0, 0, 0);
    drain();
    repeat (100) @(posedge clk);

    $display("Covered %0d load words, %0d runs and %0d register writes.",
             loads_queued, runs_taken, settings_used);
    $display("Checked %0d result words, %0d mismatches.", elems_checked, mismatches);
    if (mismatches == 0 && expected_elems.size() == 0) begin
      $display("ssor_preconditioner_apply: match");
    end else begin
      $display("ssor_preconditioner_apply: mismatch");
    end
    $finish;
  end

endmodule
